// ----- hw/rtl/skinned_decal_vertex_projection_macros.svh -----
// Assertion helpers for the decal projection block.
`ifndef SKINNED_DECAL_VERTEX_PROJECTION_MACROS_SVH
`define SKINNED_DECAL_VERTEX_PROJECTION_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SDVP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdvp check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SDVP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdvp check failed");

`endif

// ----- hw/rtl/sdvp_pkg.sv -----
package sdvp_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int WORDS_PER_BONE   = 12;
  localparam int BONES_PER_VERTEX = 3;
  localparam int ROW_BITS         = WORDS_PER_BONE * 32;
  localparam int DIV_BITS         = 48;
  localparam logic [31:0] ONE_Q   = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] HALF_Q  = 32'(64'd1 << (FRAC_BITS - 1));
  localparam logic [31:0] EPS_Q   = 32'(((64'd1 << FRAC_BITS) + 64'd9) / 64'd10);

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_VERTEX = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_NO_POKE  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic               func;
    logic [10:0]        matrix_addr;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [1:0]         bone_count;
    logic [20:0]        bone_ids;
    logic [47:0]        bone_weights;
  } in_t;

  typedef struct packed {
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
    logic               is_front;
    logic               in_area;
  } out_t;

  // Flags that ride along the divider next to the two quotients.
  typedef struct packed {
    logic       front;
    logic       area;
    logic [1:0] neg;
  } div_side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sdvp_ram.sv -----
module sdvp_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [3:0]                    wword_i,
  input  logic [31:0]                   wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [sdvp_pkg::ROW_BITS-1:0] rdata_o
);

  logic [sdvp_pkg::ROW_BITS-1:0] mem_q [DEPTH];
  logic [sdvp_pkg::ROW_BITS-1:0] rdata_q;

  // One word lane of a bone row per write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wword_i*32 +: 32] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sdvp_div.sv -----
module sdvp_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [1:0][sdvp_pkg::DIV_BITS-1:0]   num_i,
  input  logic [31:0]                          den_i,
  input  sdvp_pkg::div_side_t                  side_i,
  output logic                                 valid_o,
  output logic [1:0][sdvp_pkg::DIV_BITS-1:0]   quot_o,
  output logic [1:0]                           rem_nz_o,
  output sdvp_pkg::div_side_t                  side_o
);

  localparam int NW = sdvp_pkg::DIV_BITS;

  logic [1:0][31:0]   rem_q  [NW];
  logic [1:0][NW-1:0] quot_q [NW];
  logic [1:0][NW-1:0] num_q  [NW];
  sdvp_pkg::div_side_t side_q [NW];
  logic [NW-1:0]      vld_q;

  // One quotient bit per stage and lane, restoring form.
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [1:0][31:0]   rem_in, rem_d;
    logic [1:0][NW-1:0] quot_in, quot_d;
    logic [1:0][NW-1:0] num_in, num_d;
    sdvp_pkg::div_side_t side_in;
    logic               vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign quot_in = '0;
      assign num_in  = num_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign quot_in = quot_q[k-1];
      assign num_in  = num_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    always_comb begin
      logic [32:0] t;
      logic        ge;
      for (int l = 0; l < 2; l++) begin
        t  = {rem_in[l], num_in[l][NW-1]};
        ge = (t >= {1'b0, den_i});
        rem_d[l]  = ge ? 32'(t - {1'b0, den_i}) : t[31:0];
        quot_d[l] = {quot_in[l][NW-2:0], ge};
        num_d[l]  = {num_in[l][NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quot_q[k] <= quot_d;
        num_q[k]  <= num_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o     = vld_q[NW-1];
  assign quot_o      = quot_q[NW-1];
  assign rem_nz_o[0] = |rem_q[NW-1][0];
  assign rem_nz_o[1] = |rem_q[NW-1][1];
  assign side_o      = side_q[NW-1];

endmodule

// ----- hw/rtl/skinned_decal_vertex_projection.sv -----
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | in_i  (sdvp_pkg::in_t)
// out     | output    | out_valid_o / out_stall_i | out_o (sdvp_pkg::out_t)
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
// One item enters per cycle unless stalled; a vertex result then passes
// memory read, four arithmetic stages, 48 divider stages, output register.
// The 48-stage divider that scales u and v by 1/(2r) sets the latency.
// A matrix write finishes at its accept edge and gives no result.
// Reset clears valid bits and config (radius 1.0, culling off); the matrix
// table holds garbage until written; stalled valid output freezes all stages.
module skinned_decal_vertex_projection #(
  parameter int MAX_BONES = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdvp_pkg::in_t       in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdvp_pkg::out_t      out_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [30:0]         cfg_wdata_i
);

  localparam int AW          = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int TABLE_DEPTH = MAX_BONES * sdvp_pkg::WORDS_PER_BONE;
  localparam int NB          = sdvp_pkg::BONES_PER_VERTEX;

  // ---------------- configuration ----------------
  logic [30:0] radius_q;
  logic        npt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 31'(sdvp_pkg::ONE_Q);
      npt_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdvp_pkg::CFG_RADIUS:  radius_q <= cfg_wdata_i;
        sdvp_pkg::CFG_NO_POKE: npt_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  // Freeze everything while a finished result waits.
  logic        en;
  logic        out_valid_q;
  logic        acc;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  // ---------------- table write ----------------
  // bone = addr / 12 via (addr >> 2) * 171 >> 9, exact for 9-bit operands.
  logic [16:0] div_p;
  logic [7:0]  wbone;
  logic [3:0]  wword;
  logic        wr_en;

  assign div_p = 17'(in_i.matrix_addr[10:2]) * 17'd171;
  assign wbone = div_p[16:9];
  assign wword = 4'(in_i.matrix_addr - 11'(wbone) * 11'd12);
  assign wr_en = acc && (in_i.func == sdvp_pkg::FUNC_WRITE) &&
                 (32'(in_i.matrix_addr) < 32'(TABLE_DEPTH));

  // ---------------- stage 0: table read ----------------
  logic [NB-1:0][sdvp_pkg::ROW_BITS-1:0] rdata;

  for (genvar b = 0; b < NB; b++) begin : g_ram
    logic [7:0] rid;
    assign rid = {1'b0, in_i.bone_ids[7*b +: 7]};
    sdvp_ram #(.DEPTH(MAX_BONES), .AW(AW)) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en),
      .waddr_i (wbone[AW-1:0]),
      .wword_i (wword),
      .wdata_i (in_i.matrix_value),
      .re_i    (en),
      .raddr_i (rid[AW-1:0]),
      .rdata_o (rdata[b])
    );
  end

  logic               v1_q;
  logic signed [31:0] pos1_q [3];
  logic signed [31:0] nrm1_q [3];
  logic [1:0]         cnt1_q;
  logic [47:0]        wts1_q;
  logic [NB-1:0]      oob1_q;
  logic [1:0]         cnt0;
  logic [NB-1:0]      oob0;

  always_comb begin
    cnt0 = (in_i.bone_count == 2'd0) ? 2'd1 : in_i.bone_count;
    if (cnt0 > 2'(NB)) begin
      cnt0 = 2'(NB);
    end
    for (int b = 0; b < NB; b++) begin
      oob0[b] = (32'(in_i.bone_ids[7*b +: 7]) >= 32'(MAX_BONES));
    end
  end

  // ---------------- stage 1: products ----------------
  logic               v2_q;
  logic signed [63:0] pp2_q [NB][9];
  logic signed [63:0] np2_q [NB][3];
  logic signed [31:0] tr2_q [NB][3];
  logic [1:0]         cnt2_q;
  logic [47:0]        wts2_q;
  logic signed [63:0] pp1 [NB][9];
  logic signed [63:0] np1 [NB][3];
  logic signed [31:0] tr1 [NB][3];

  always_comb begin
    logic signed [31:0] m [12];
    for (int b = 0; b < NB; b++) begin
      for (int w = 0; w < 12; w++) begin
        m[w] = oob1_q[b] ? 32'sd0 : $signed(rdata[b][w*32 +: 32]);
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pp1[b][r*3+c] = pos1_q[c] * m[r*4+c];
        end
        tr1[b][r] = m[r*4+3];
        np1[b][r] = nrm1_q[r] * m[8+r];
      end
    end
  end

  // ---------------- stage 2: bone rows ----------------
  // Rows 0..2 are u, v, depth of the position; row 3 is the normal depth.
  logic               v3_q;
  logic signed [31:0] rw3_q [NB][4];
  logic [1:0]         cnt3_q;
  logic [47:0]        wts3_q;
  logic signed [31:0] rw2 [NB][4];

  always_comb begin
    logic signed [63:0] s;
    for (int b = 0; b < NB; b++) begin
      for (int r = 0; r < 3; r++) begin
        s = 64'(pp2_q[b][r*3] >>> sdvp_pkg::FRAC_BITS) +
            64'(pp2_q[b][r*3+1] >>> sdvp_pkg::FRAC_BITS) +
            64'(pp2_q[b][r*3+2] >>> sdvp_pkg::FRAC_BITS) + 64'(tr2_q[b][r]);
        rw2[b][r] = sdvp_pkg::sat32(s);
      end
      s = 64'(np2_q[b][0] >>> sdvp_pkg::FRAC_BITS) +
          64'(np2_q[b][1] >>> sdvp_pkg::FRAC_BITS) +
          64'(np2_q[b][2] >>> sdvp_pkg::FRAC_BITS);
      rw2[b][3] = sdvp_pkg::sat32(s);
    end
  end

  // ---------------- stage 3: weight products ----------------
  logic               v4_q;
  logic signed [48:0] wp4_q [NB][4];
  logic signed [31:0] rw04_q [4];
  logic [1:0]         cnt4_q;
  logic signed [48:0] wp3 [NB][4];

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      for (int r = 0; r < 4; r++) begin
        wp3[b][r] = 49'(rw3_q[b][r]) * $signed({1'b0, wts3_q[16*b +: 16]});
      end
    end
  end

  // ---------------- stage 4: blend ----------------
  logic               v5_q;
  logic signed [31:0] bl5_q [4];
  logic signed [31:0] bl4 [4];

  always_comb begin
    logic signed [63:0] s;
    for (int r = 0; r < 4; r++) begin
      s = '0;
      for (int b = 0; b < NB; b++) begin
        if (32'(cnt4_q) > b) begin
          s = s + 64'(wp4_q[b][r] >>> 16);
        end
      end
      bl4[r] = (cnt4_q == 2'd1) ? rw04_q[r] : sdvp_pkg::sat32(s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc && (in_i.func == sdvp_pkg::FUNC_VERTEX);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos1_q <= '{in_i.pos_x, in_i.pos_y, in_i.pos_z};
      nrm1_q <= '{in_i.nrm_x, in_i.nrm_y, in_i.nrm_z};
      cnt1_q <= cnt0;
      wts1_q <= in_i.bone_weights;
      oob1_q <= oob0;
      pp2_q  <= pp1;
      np2_q  <= np1;
      tr2_q  <= tr1;
      cnt2_q <= cnt1_q;
      wts2_q <= wts1_q;
      rw3_q  <= rw2;
      cnt3_q <= cnt2_q;
      wts3_q <= wts2_q;
      wp4_q  <= wp3;
      rw04_q <= rw3_q[0];
      cnt4_q <= cnt3_q;
      bl5_q  <= bl4;
    end
  end

  // ---------------- stage 5: facing, area, divider feed ----------------
  logic [1:0][sdvp_pkg::DIV_BITS-1:0] num5;
  logic [31:0]                         den;
  sdvp_pkg::div_side_t                 side5;
  logic [32:0]                         dabs;

  always_comb begin
    logic [31:0] mag;
    for (int l = 0; l < 2; l++) begin
      side5.neg[l] = bl5_q[l][31];
      mag          = bl5_q[l][31] ? 32'(-bl5_q[l]) : 32'(bl5_q[l]);
      num5[l]      = {mag, {sdvp_pkg::FRAC_BITS{1'b0}}};
    end
    dabs        = bl5_q[2][31] ? 33'(-34'(bl5_q[2])) : 33'(bl5_q[2]);
    side5.front = (bl5_q[3] >= $signed(sdvp_pkg::EPS_Q));
    side5.area  = npt_q ? (dabs < 33'(radius_q)) : 1'b1;
    den         = (radius_q == 31'd0) ? 32'(sdvp_pkg::ONE_Q) << 1 : {radius_q, 1'b0};
  end

  logic                                dv_valid;
  logic [1:0][sdvp_pkg::DIV_BITS-1:0] dv_quot;
  logic [1:0]                          dv_nz;
  sdvp_pkg::div_side_t                 dv_side;

  sdvp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v5_q),
    .num_i    (num5),
    .den_i    (den),
    .side_i   (side5),
    .valid_o  (dv_valid),
    .quot_o   (dv_quot),
    .rem_nz_o (dv_nz),
    .side_o   (dv_side)
  );

  // ---------------- output register ----------------
  // Floor for negative numerators: take the ceiling of the magnitude.
  sdvp_pkg::out_t out_d, out_q;

  always_comb begin
    logic signed [63:0] q [2];
    for (int l = 0; l < 2; l++) begin
      q[l] = 64'(dv_quot[l]) + 64'(dv_nz[l] & dv_side.neg[l]);
      if (dv_side.neg[l]) begin
        q[l] = -q[l];
      end
      q[l] = q[l] + 64'(sdvp_pkg::HALF_Q);
    end
    out_d.is_front = dv_side.front;
    out_d.in_area  = dv_side.front && dv_side.area;
    out_d.u_coord  = dv_side.front ? sdvp_pkg::sat32(q[0]) : 32'sd0;
    out_d.v_coord  = dv_side.front ? sdvp_pkg::sat32(q[1]) : 32'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------- checks ----------------
`include "skinned_decal_vertex_projection_macros.svh"

  `SDVP_ASSERT_NOW(a_back_zero, out_valid_o && !out_o.is_front, out_o.u_coord == 32'sd0 && out_o.v_coord == 32'sd0 && !out_o.in_area)
  `SDVP_ASSERT_NOW(a_no_cull_in_area, out_valid_o && out_o.is_front && !npt_q, out_o.in_area)
  `SDVP_ASSERT_NOW(a_zero_radius_cull, out_valid_o && npt_q && radius_q == 31'd0, !out_o.in_area)
  `SDVP_ASSERT_NOW(a_stall_needs_out, in_stall_o, out_valid_o)
  `SDVP_ASSERT_NEXT(a_stall_keeps_out, in_stall_o, out_valid_o)

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_WORDS = 128 * sdvp_pkg::WORDS_PER_BONE;
  localparam int DRAIN_CYCLES = 64;     // pipeline is 54 deep
  localparam int HOLD_CYCLES = 400;     // long output hold-off
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sdvp_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sdvp_pkg::out_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [30:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  skinned_decal_vertex_projection uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shared state between the stimulus, driver and monitors.
  sdvp_pkg::in_t pending_q[$];
  sdvp_pkg::out_t expected_uv_q[$];
  int sender_gap_pct = 0;
  int receiver_gap_pct = 0;
  int hold_req = 0;
  logic in_took = 1'b0;
  int errors = 0;
  int vertex_cnt = 0, front_cnt = 0, area_cnt = 0, write_cnt = 0;

  // Predictor copy of the pose table and registers.
  logic signed [31:0] pose_words [TABLE_WORDS];
  logic [30:0] radius_q = 31'd65536;
  logic cull_en = 1'b0;

  // Bones whose twelve words have all been queued for writing.
  int ready_bones[$];

  function automatic longint clamp_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One bone's matrix row applied to a vector; translation only when affine.
  function automatic longint bone_dot(input int bone, input int row,
                                      input longint vec[3], input bit affine);
    longint acc;
    int base;
    acc = 0;
    if (bone >= 128) return 0;
    base = bone * sdvp_pkg::WORDS_PER_BONE + row * 4;
    for (int c = 0; c < 3; c++)
      acc += (vec[c] * longint'(pose_words[base + c])) >>> sdvp_pkg::FRAC_BITS;
    if (affine) acc += longint'(pose_words[base + 3]);
    return clamp_word(acc);
  endfunction

  function automatic longint weighted_row(input int cnt, input int ids[3],
                                          input longint wts[3], input int row,
                                          input longint vec[3], input bit affine);
    longint acc;
    acc = 0;
    if (cnt == 1) return bone_dot(ids[0], row, vec, affine);
    for (int i = 0; i < cnt; i++)
      acc += (bone_dot(ids[i], row, vec, affine) * wts[i]) >>> 16;
    return clamp_word(acc);
  endfunction

  // Scale into texture space: floor(c / 2r) + 0.5.
  function automatic longint tex_scale(input longint c, input longint r);
    longint num, den, q;
    num = c * 65536;
    den = 2 * r;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return clamp_word(q + 32768);
  endfunction

  // Apply one accepted item; vertices push their projected result.
  task automatic project_item(input sdvp_pkg::in_t it);
    sdvp_pkg::out_t res;
    longint pos[3], nrm[3], wts[3];
    int ids[3];
    int cnt;
    longint depth, r;
    res = '0;
    if (it.func == sdvp_pkg::FUNC_WRITE) begin
      if (it.matrix_addr < TABLE_WORDS) pose_words[it.matrix_addr] = it.matrix_value;
      write_cnt++;
      return;
    end
    pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
    nrm[0] = it.nrm_x; nrm[1] = it.nrm_y; nrm[2] = it.nrm_z;
    cnt = (it.bone_count == 0) ? 1 : int'(it.bone_count);
    for (int i = 0; i < 3; i++) begin
      ids[i] = int'(it.bone_ids[7*i +: 7]);
      wts[i] = longint'(it.bone_weights[16*i +: 16]);
    end
    if (weighted_row(cnt, ids, wts, 2, nrm, 1'b0) >= longint'(sdvp_pkg::EPS_Q)) begin
      res.is_front = 1'b1;
      if (cull_en) begin
        depth = weighted_row(cnt, ids, wts, 2, pos, 1'b1);
        if (depth < 0) depth = -depth;
        res.in_area = depth < longint'(radius_q);
      end else begin
        res.in_area = 1'b1;
      end
      r = (radius_q != 0) ? longint'(radius_q) : 65536;
      res.u_coord = 32'(tex_scale(weighted_row(cnt, ids, wts, 0, pos, 1'b1), r));
      res.v_coord = 32'(tex_scale(weighted_row(cnt, ids, wts, 1, pos, 1'b1), r));
    end
    vertex_cnt++;
    front_cnt += int'(res.is_front);
    area_cnt += int'(res.in_area);
    expected_uv_q.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Input side: accept at the rising edge, advance the predictor.
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) project_item(in_item);
  end

  // Output side: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    sdvp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_uv_q.size() == 0) begin
        report_mismatch("unexpected item", longint'(out_item.u_coord), 0);
      end else begin
        want = expected_uv_q.pop_front();
        if (out_item.u_coord !== want.u_coord)
          report_mismatch("u_coord", out_item.u_coord, want.u_coord);
        if (out_item.v_coord !== want.v_coord)
          report_mismatch("v_coord", out_item.v_coord, want.v_coord);
        if (out_item.is_front !== want.is_front)
          report_mismatch("is_front", out_item.is_front, want.is_front);
        if (out_item.in_area !== want.in_area)
          report_mismatch("in_area", out_item.in_area, want.in_area);
      end
    end
  end

  // Driver: hold a stalled item, otherwise pop the next one or idle.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
        in_item <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    int hold_seen, hold_left;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_gap_pct);
    end
  end

  // Watchdog: count cycles in which nothing moves.
  always @(posedge clk) begin
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_uv_q.size());
        $display("skinned_decal_vertex_projection test failed");
        $finish;
      end
    end
  end

  function automatic sdvp_pkg::in_t write_item(input int addr, input logic [31:0] value);
    sdvp_pkg::in_t it;
    it = '0;
    it.func = sdvp_pkg::FUNC_WRITE;
    it.matrix_addr = 11'(addr);
    it.matrix_value = value;
    return it;
  endfunction

  task automatic queue_write(input int addr, input logic [31:0] value);
    pending_q.push_back(write_item(addr, value));
  endtask

  // Moderate values mostly, full range now and then.
  function automatic logic [31:0] rand_word(input int wide_pct);
    if ($urandom_range(99) < wide_pct) return $urandom;
    return $urandom_range(262143) - 131072;
  endfunction

  task automatic load_bone(input int bone);
    bit known;
    for (int w = 0; w < sdvp_pkg::WORDS_PER_BONE; w++)
      queue_write(bone * sdvp_pkg::WORDS_PER_BONE + w, rand_word(10));
    known = 0;
    foreach (ready_bones[i]) if (ready_bones[i] == bone) known = 1;
    if (!known) ready_bones.push_back(bone);
  endtask

  function automatic sdvp_pkg::in_t vertex_item(input int cnt);
    sdvp_pkg::in_t it;
    int used;
    it = '0;
    it.func = sdvp_pkg::FUNC_VERTEX;
    it.matrix_addr = 11'($urandom);
    it.matrix_value = $urandom;
    it.pos_x = rand_word(20); it.pos_y = rand_word(20); it.pos_z = rand_word(20);
    it.nrm_x = rand_word(15); it.nrm_y = rand_word(15); it.nrm_z = rand_word(15);
    it.bone_count = 2'(cnt);
    it.bone_ids = 21'($urandom);
    it.bone_weights = 48'({$urandom, $urandom});
    used = (cnt == 0) ? 1 : cnt;
    // Only slots in use must point at fully loaded bones.
    for (int i = 0; i < used; i++)
      it.bone_ids[7*i +: 7] = 7'(ready_bones[$urandom_range(ready_bones.size() - 1)]);
    return it;
  endfunction

  // Random phase: mostly vertices over loaded bones, some table traffic.
  task automatic random_phase(input int n);
    int roll, bone;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        bone = ready_bones[$urandom_range(ready_bones.size() - 1)];
        queue_write(bone * sdvp_pkg::WORDS_PER_BONE + $urandom_range(11), rand_word(10));
      end else if (roll < 14) begin
        queue_write($urandom_range(2047, TABLE_WORDS), $urandom);
      end else if (roll < 15) begin
        load_bone($urandom_range(127));
      end else begin
        pending_q.push_back(vertex_item($urandom_range(3)));
      end
    end
  endtask

  // Wait until every item has gone in and every result has come out.
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_uv_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == sdvp_pkg::CFG_RADIUS) radius_q = value;
    else if (idx == sdvp_pkg::CFG_NO_POKE) cull_en = value[0];
  endtask

  initial begin
    sdvp_pkg::in_t it;
    logic [30:0] radius_set [6];
    logic cull_set [6];
    radius_set = '{31'd65536, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'd163840, 31'h5555_5555};
    cull_set = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    sender_gap_pct = 21;
    receiver_gap_pct = 83;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bone 0: identity with unit depth row; a few more to toggle all id bits.
    for (int w = 0; w < sdvp_pkg::WORDS_PER_BONE; w++)
      queue_write(w, (w == 0 || w == 5 || w == 10) ? 32'h0001_0000 : 32'h0);
    ready_bones.push_back(0);
    load_bone(127);
    load_bone(85);
    load_bone(42);

    // Directed: facing threshold, field extremes, bone counts, bad address.
    it = vertex_item(1); it.bone_ids[6:0] = 0;
    it.nrm_x = 0; it.nrm_y = 0; it.nrm_z = 32'sd6553;
    pending_q.push_back(it);
    it.nrm_z = 32'sd6554;
    pending_q.push_back(it);
    it.pos_x = 32'sh7FFF_FFFF; it.pos_y = 32'sh8000_0000; it.pos_z = 32'sh7FFF_FFFF;
    pending_q.push_back(it);
    it.pos_x = 32'sh8000_0000; it.pos_y = 32'sh7FFF_FFFF; it.pos_z = 32'sh8000_0000;
    pending_q.push_back(it);
    it.nrm_z = 32'sh8000_0000;
    pending_q.push_back(it);
    it = vertex_item(0); it.nrm_x = 32'sh7FFF_FFFF; it.nrm_y = 32'sh7FFF_FFFF;
    it.nrm_z = 32'sh7FFF_FFFF;
    pending_q.push_back(it);
    it = vertex_item(3); it.bone_weights = '1;
    pending_q.push_back(it);
    it = vertex_item(2); it.bone_weights = '0;
    pending_q.push_back(it);
    it = vertex_item(3); it.bone_ids = {7'd85, 7'd42, 7'd127};
    pending_q.push_back(it);
    queue_write(2047, 32'hFFFF_FFFF);
    queue_write(TABLE_WORDS, 32'h1234_5678);
    queue_write(TABLE_WORDS - 1, 32'h8000_0000);
    for (int k = 0; k < 6; k++) pending_q.push_back(vertex_item($urandom_range(3)));
    wait_idle();
    write_reg(CFG_SPARE, '1);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sdvp_pkg::CFG_RADIUS, radius_set[ph]);
      write_reg(sdvp_pkg::CFG_NO_POKE, cull_set[ph]);
      if (ph == 2) begin
        sender_gap_pct = 83;
        receiver_gap_pct = 21;
      end else if (ph == 4) begin
        sender_gap_pct = 0;
        receiver_gap_pct = 0;
      end
      if (ph == 1) begin
        // Freeze the output while the sender keeps offering items.
        hold_req++;
        random_phase(110);
        wait_idle();
      end
      random_phase(145);
      wait_idle();
    end

    $display("covered %0d vertices (%0d front-facing, %0d in area) and %0d table writes",
             vertex_cnt, front_cnt, area_cnt, write_cnt);
    $display("across six radius and culling settings with %0d mismatches", errors);
    if (errors == 0) begin
      $display("skinned_decal_vertex_projection test passed");
    end else begin
      $display("skinned_decal_vertex_projection test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sdvp_pkg.sv
hw/rtl/sdvp_ram.sv
hw/rtl/sdvp_div.sv
hw/rtl/skinned_decal_vertex_projection.sv
test/testbench.sv
